// File: design/hrhp_pkg.sv
// Package with the word types, codes and character classes of the request head parser.
`default_nettype none
package hrhp_pkg;

    // Input word: one byte of the request head or an end-of-stream mark.
    typedef struct packed {
        logic [7:0] data_byte_in;
        logic       end_of_stream;
    } req_word_t;

    // Result word produced for every input word.
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] byte_kind;
        logic [7:0] data_byte_out;
        logic       header_start;
        logic [2:0] method_code;
        logic       method_valid;
        logic [1:0] target_form;
    } res_word_t;

    // Parser states.
    typedef enum logic [4:0] {
        ST_METHOD     = 5'd0,
        ST_TGT_START  = 5'd1,
        ST_AST_SKIP   = 5'd2,
        ST_PATH       = 5'd3,
        ST_PATH_PCT1  = 5'd4,
        ST_PATH_PCT2  = 5'd5,
        ST_QUERY      = 5'd6,
        ST_QUERY_PCT1 = 5'd7,
        ST_QUERY_PCT2 = 5'd8,
        ST_SCHEME     = 5'd9,
        ST_SLASH1     = 5'd10,
        ST_SLASH2     = 5'd11,
        ST_AUTH       = 5'd12,
        ST_LINE_END   = 5'd13,
        ST_HDR_START  = 5'd14,
        ST_HDR_CR     = 5'd15,
        ST_HDR_NAME   = 5'd16,
        ST_HDR_OWS    = 5'd17,
        ST_HDR_VALUE  = 5'd18,
        ST_HDR_SKIP   = 5'd19
    } state_t;

    // Parser context that has a fixed width.
    typedef struct packed {
        state_t     st;
        logic [3:0] nib;
        logic [2:0] meth;
        logic [1:0] form;
        logic       saw;
    } ctx_t;

    // Status codes.
    localparam logic [1:0] STATUS_BUSY = 2'd0;
    localparam logic [1:0] STATUS_OK   = 2'd1;
    localparam logic [1:0] STATUS_FAIL = 2'd2;

    // Byte kinds.
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_PATH   = 3'd1;
    localparam logic [2:0] KIND_QUERY  = 3'd2;
    localparam logic [2:0] KIND_SCHEME = 3'd3;
    localparam logic [2:0] KIND_AUTH   = 3'd4;
    localparam logic [2:0] KIND_HNAME  = 3'd5;
    localparam logic [2:0] KIND_HVALUE = 3'd6;

    // Target forms.
    localparam logic [1:0] FORM_NONE     = 2'd0;
    localparam logic [1:0] FORM_ASTERISK = 2'd1;
    localparam logic [1:0] FORM_ORIGIN   = 2'd2;
    localparam logic [1:0] FORM_ABSOLUTE = 2'd3;

    // Characters with a role in the grammar.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    // Method names, left aligned in seven bytes, and their lengths.
    localparam int         VERB_BYTES = 7;
    localparam logic [55:0] VERB_TEXT [8] = '{
        {"GET", 32'h0}, {"HEAD", 24'h0}, {"POST", 24'h0}, {"PUT", 32'h0},
        {"DELETE", 8'h0}, "CONNECT", "OPTIONS", {"TRACE", 16'h0}
    };
    localparam logic [4:0] VERB_LEN [8] = '{
        5'd3, 5'd4, 5'd4, 5'd3, 5'd6, 5'd7, 5'd7, 5'd5
    };

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_graph(input logic [7:0] c);
        return c >= 8'h21 && c <= 8'h7E;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    // Token characters: letters, digits and ! # $ % & ' * + - . ^ _ ` | ~
    function automatic logic is_token_char(input logic [7:0] c);
        return is_alnum(c) || c == 8'h21 || c == 8'h23 || c == 8'h24 ||
               c == 8'h25 || c == 8'h26 || c == 8'h27 || c == 8'h2A ||
               c == 8'h2B || c == 8'h2D || c == 8'h2E || c == 8'h5E ||
               c == 8'h5F || c == 8'h60 || c == 8'h7C || c == 8'h7E;
    endfunction

    // Path characters that stand for themselves: letters, digits, - . _ ~ : @
    // and the sub-delimiters ! $ & ' ( ) * + , ; =
    function automatic logic is_plain_pchar(input logic [7:0] c);
        return is_alnum(c) || c == 8'h2D || c == 8'h2E || c == 8'h5F ||
               c == 8'h7E || c == 8'h3A || c == 8'h40 || c == 8'h21 ||
               c == 8'h24 || c == 8'h26 || c == 8'h27 || c == 8'h28 ||
               c == 8'h29 || c == 8'h2A || c == 8'h2B || c == 8'h2C ||
               c == 8'h3B || c == 8'h3D;
    endfunction

    // Hex digit value; bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else begin
            d = 8'h10;
        end
        return d[4:0];
    endfunction

endpackage
`default_nettype wire

// File: design/hrhp_step.sv
// Next-state and result logic of the request head parser for one byte.
`default_nettype none
module hrhp_step #(
    parameter int MAX_LEN = 7,
    parameter int LW      = 3
) (
    input  hrhp_pkg::req_word_t      word,
    input  hrhp_pkg::ctx_t           ctx,
    input  logic [LW-1:0]            len,
    input  logic [MAX_LEN*8-1:0]     mbuf,
    output hrhp_pkg::ctx_t           ctx_next,
    output logic [LW-1:0]            len_next,
    output logic                     buf_wr,
    output hrhp_pkg::res_word_t      res
);

    logic [7:0]     b;
    logic [7:0]     lc;
    logic [4:0]     hv;
    logic           scheme_go;
    logic           meth_hit;
    logic [2:0]     meth_code;
    logic [1:0]     status;
    logic [2:0]     kind;
    logic [7:0]     dout;
    logic           hs;
    hrhp_pkg::ctx_t nx;
    logic [LW-1:0]  len_nx;

    assign b  = word.data_byte_in;
    assign lc = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    assign hv = hrhp_pkg::hex_val(b);

    // Method token match against the eight names; the lowest code wins.
    always_comb
    begin
        logic same;
        meth_hit  = 1'b0;
        meth_code = 3'd0;
        for (int m = 7; m >= 0; m--) begin
            same = ({{(32-LW){1'b0}}, len} == {27'd0, hrhp_pkg::VERB_LEN[m]});
            for (int i = 0; i < hrhp_pkg::VERB_BYTES; i++) begin
                if (i < int'(hrhp_pkg::VERB_LEN[m]) &&
                    mbuf[i*8 +: 8] != hrhp_pkg::VERB_TEXT[m][(6-i)*8 +: 8]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                meth_hit  = 1'b1;
                meth_code = 3'(m);
            end
        end
    end

    // Parser transition for one byte.
    always_comb
    begin
        nx        = ctx;
        len_nx    = len;
        buf_wr    = 1'b0;
        status    = hrhp_pkg::STATUS_BUSY;
        kind      = hrhp_pkg::KIND_NONE;
        dout      = 8'h00;
        hs        = 1'b0;
        scheme_go = 1'b0;
        if (word.end_of_stream) begin
            status = hrhp_pkg::STATUS_FAIL;
        end else begin
            unique case (ctx.st)
                hrhp_pkg::ST_METHOD:
                begin
                    if (hrhp_pkg::is_token_char(b)) begin
                        if (len >= LW'(MAX_LEN)) begin
                            status = hrhp_pkg::STATUS_FAIL;
                        end else begin
                            buf_wr = 1'b1;
                            len_nx = len + LW'(1);
                        end
                    end else if (b == hrhp_pkg::CH_SPACE && len != '0 && meth_hit) begin
                        nx.meth = meth_code;
                        nx.st   = hrhp_pkg::ST_TGT_START;
                    end else begin
                        status = hrhp_pkg::STATUS_FAIL;
                    end
                end
                hrhp_pkg::ST_TGT_START:
                begin
                    if (b == hrhp_pkg::CH_STAR) begin
                        nx.form = hrhp_pkg::FORM_ASTERISK;
                        nx.st   = hrhp_pkg::ST_AST_SKIP;
                    end else if (b == hrhp_pkg::CH_SLASH) begin
                        nx.form = hrhp_pkg::FORM_ORIGIN;
                        kind    = hrhp_pkg::KIND_PATH;
                        dout    = b;
                        nx.st   = hrhp_pkg::ST_PATH;
                    end else begin
                        nx.form   = hrhp_pkg::FORM_ABSOLUTE;
                        nx.st     = hrhp_pkg::ST_SCHEME;
                        scheme_go = 1'b1;
                    end
                end
                hrhp_pkg::ST_AST_SKIP:
                begin
                    nx.st = hrhp_pkg::ST_LINE_END;
                end
                hrhp_pkg::ST_SCHEME:
                begin
                    scheme_go = 1'b1;
                end
                hrhp_pkg::ST_SLASH1, hrhp_pkg::ST_SLASH2:
                begin
                    if (b == hrhp_pkg::CH_SLASH) begin
                        nx.st = (ctx.st == hrhp_pkg::ST_SLASH1) ?
                                hrhp_pkg::ST_SLASH2 : hrhp_pkg::ST_AUTH;
                    end else begin
                        status = hrhp_pkg::STATUS_FAIL;
                    end
                end
                hrhp_pkg::ST_AUTH:
                begin
                    if (b == hrhp_pkg::CH_SLASH) begin
                        kind  = hrhp_pkg::KIND_PATH;
                        dout  = b;
                        nx.st = hrhp_pkg::ST_PATH;
                    end else if (hrhp_pkg::is_graph(b)) begin
                        kind = hrhp_pkg::KIND_AUTH;
                        dout = b;
                    end else begin
                        status = hrhp_pkg::STATUS_FAIL;
                    end
                end
                hrhp_pkg::ST_PATH:
                begin
                    if (b == hrhp_pkg::CH_QUEST) begin
                        nx.st = hrhp_pkg::ST_QUERY;
                    end else if (b == hrhp_pkg::CH_SPACE) begin
                        nx.st = hrhp_pkg::ST_LINE_END;
                    end else if (b == hrhp_pkg::CH_SLASH || hrhp_pkg::is_plain_pchar(b)) begin
                        kind = hrhp_pkg::KIND_PATH;
                        dout = b;
                    end else if (b == hrhp_pkg::CH_PERCENT) begin
                        nx.st = hrhp_pkg::ST_PATH_PCT1;
                    end else begin
                        status = hrhp_pkg::STATUS_FAIL;
                    end
                end
                hrhp_pkg::ST_QUERY:
                begin
                    if (b == hrhp_pkg::CH_SPACE) begin
                        nx.st = hrhp_pkg::ST_LINE_END;
                    end else if (b == hrhp_pkg::CH_SLASH || b == hrhp_pkg::CH_QUEST ||
                                 hrhp_pkg::is_plain_pchar(b)) begin
                        kind = hrhp_pkg::KIND_QUERY;
                        dout = b;
                    end else if (b == hrhp_pkg::CH_PERCENT) begin
                        nx.st = hrhp_pkg::ST_QUERY_PCT1;
                    end else begin
                        status = hrhp_pkg::STATUS_FAIL;
                    end
                end
                hrhp_pkg::ST_PATH_PCT1, hrhp_pkg::ST_QUERY_PCT1:
                begin
                    if (hv[4]) begin
                        status = hrhp_pkg::STATUS_FAIL;
                    end else begin
                        nx.nib = hv[3:0];
                        nx.st  = (ctx.st == hrhp_pkg::ST_PATH_PCT1) ?
                                 hrhp_pkg::ST_PATH_PCT2 : hrhp_pkg::ST_QUERY_PCT2;
                    end
                end
                hrhp_pkg::ST_PATH_PCT2, hrhp_pkg::ST_QUERY_PCT2:
                begin
                    if (hv[4]) begin
                        status = hrhp_pkg::STATUS_FAIL;
                    end else begin
                        dout = {ctx.nib, hv[3:0]};
                        if (ctx.st == hrhp_pkg::ST_PATH_PCT2) begin
                            kind  = hrhp_pkg::KIND_PATH;
                            nx.st = hrhp_pkg::ST_PATH;
                        end else begin
                            kind  = hrhp_pkg::KIND_QUERY;
                            nx.st = hrhp_pkg::ST_QUERY;
                        end
                    end
                end
                hrhp_pkg::ST_LINE_END, hrhp_pkg::ST_HDR_SKIP:
                begin
                    if (b == hrhp_pkg::CH_LF) begin
                        nx.st = hrhp_pkg::ST_HDR_START;
                    end
                end
                hrhp_pkg::ST_HDR_START:
                begin
                    if (b == hrhp_pkg::CH_LF) begin
                        status = hrhp_pkg::STATUS_OK;
                    end else if (b == hrhp_pkg::CH_CR) begin
                        nx.st = hrhp_pkg::ST_HDR_CR;
                    end else if (hrhp_pkg::is_token_char(b)) begin
                        kind  = hrhp_pkg::KIND_HNAME;
                        dout  = b;
                        hs    = 1'b1;
                        nx.st = hrhp_pkg::ST_HDR_NAME;
                    end else begin
                        status = hrhp_pkg::STATUS_FAIL;
                    end
                end
                hrhp_pkg::ST_HDR_CR:
                begin
                    status = (b == hrhp_pkg::CH_LF) ? hrhp_pkg::STATUS_OK :
                                                      hrhp_pkg::STATUS_FAIL;
                end
                hrhp_pkg::ST_HDR_NAME:
                begin
                    if (hrhp_pkg::is_token_char(b)) begin
                        kind = hrhp_pkg::KIND_HNAME;
                        dout = b;
                    end else if (b == hrhp_pkg::CH_COLON) begin
                        nx.st = hrhp_pkg::ST_HDR_OWS;
                    end else begin
                        status = hrhp_pkg::STATUS_FAIL;
                    end
                end
                hrhp_pkg::ST_HDR_OWS:
                begin
                    if (hrhp_pkg::is_blank(b)) begin
                        nx.st = ctx.st;
                    end else if (hrhp_pkg::is_graph(b)) begin
                        kind  = hrhp_pkg::KIND_HVALUE;
                        dout  = b;
                        nx.st = hrhp_pkg::ST_HDR_VALUE;
                    end else begin
                        nx.st = (b == hrhp_pkg::CH_LF) ? hrhp_pkg::ST_HDR_START :
                                                         hrhp_pkg::ST_HDR_SKIP;
                    end
                end
                hrhp_pkg::ST_HDR_VALUE:
                begin
                    if (hrhp_pkg::is_graph(b) || hrhp_pkg::is_blank(b)) begin
                        kind = hrhp_pkg::KIND_HVALUE;
                        dout = b;
                    end else begin
                        nx.st = (b == hrhp_pkg::CH_LF) ? hrhp_pkg::ST_HDR_START :
                                                         hrhp_pkg::ST_HDR_SKIP;
                    end
                end
                default:
                begin
                    status = hrhp_pkg::STATUS_FAIL;
                end
            endcase

            // Scheme bytes, lower-cased; a colon closes a non-empty scheme.
            if (scheme_go) begin
                if (b == hrhp_pkg::CH_COLON) begin
                    if (ctx.saw) begin
                        nx.st = hrhp_pkg::ST_SLASH1;
                    end else begin
                        status = hrhp_pkg::STATUS_FAIL;
                    end
                end else if (hrhp_pkg::is_alnum(lc) || lc == 8'h2B || lc == 8'h2D ||
                             lc == 8'h2E) begin
                    nx.saw = 1'b1;
                    kind   = hrhp_pkg::KIND_SCHEME;
                    dout   = lc;
                end else begin
                    status = hrhp_pkg::STATUS_FAIL;
                end
            end
        end

        // A failure carries no byte.
        if (status == hrhp_pkg::STATUS_FAIL) begin
            kind = hrhp_pkg::KIND_NONE;
            dout = 8'h00;
            hs   = 1'b0;
        end
    end

    // Result word, then return to a fresh request after a final status.
    always_comb
    begin
        res.status        = status;
        res.byte_kind     = kind;
        res.data_byte_out = dout;
        res.header_start  = hs;
        res.method_code   = nx.meth;
        res.method_valid  = (nx.st != hrhp_pkg::ST_METHOD);
        res.target_form   = nx.form;
        if (status != hrhp_pkg::STATUS_BUSY) begin
            ctx_next.st   = hrhp_pkg::ST_METHOD;
            ctx_next.nib  = 4'h0;
            ctx_next.meth = 3'd0;
            ctx_next.form = hrhp_pkg::FORM_NONE;
            ctx_next.saw  = 1'b0;
            len_next      = '0;
        end else begin
            ctx_next = nx;
            len_next = len_nx;
        end
    end

endmodule
`default_nettype wire

// File: design/http_request_head_parser.sv
// Top level of the request head parser: context registers and a two-word result buffer.
//
//  Channel | Direction | Handshake             | Word
//  --------+-----------+-----------------------+----------------------
//  req     | in        | req_valid / req_stall | hrhp_pkg::req_word_t
//  res     | out       | res_valid / res_stall | hrhp_pkg::res_word_t
//
// Each word is parsed in the cycle it is accepted; its result goes to the result
// register, or to the skid register while that one holds a stalled result. One word per
// cycle is sustained while res_stall is low. The parser context update is a single state
// transition with character class checks. Reset puts the parser at the start of a
// request with no result pending. A stalled result parks in a second result register;
// req_stall rises only while both result registers are full.
`default_nettype none
module http_request_head_parser #(
    parameter int METHOD_MAX_LEN = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  hrhp_pkg::req_word_t req_word,
    output logic                res_valid,
    input  logic                res_stall,
    output hrhp_pkg::res_word_t res_word
);

    localparam int LW = $clog2(METHOD_MAX_LEN + 1);
    localparam int IW = $clog2(METHOD_MAX_LEN);

    hrhp_pkg::ctx_t            ctx_reg;
    hrhp_pkg::ctx_t            ctx_next;
    logic [LW-1:0]             len_reg;
    logic [LW-1:0]             len_next;
    logic [METHOD_MAX_LEN*8-1:0] mbuf_reg;
    logic                      buf_wr;
    hrhp_pkg::res_word_t       step_res;
    hrhp_pkg::res_word_t       out_reg;
    hrhp_pkg::res_word_t       skid_reg;
    logic                      out_valid_reg;
    logic                      skid_valid_reg;
    logic                      accept;
    logic                      taken;

    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !skid_valid_reg;
    assign taken     = out_valid_reg && !res_stall;
    assign res_valid = out_valid_reg;
    assign res_word  = out_reg;

    hrhp_step #(
        .MAX_LEN (METHOD_MAX_LEN),
        .LW      (LW)
    ) u_step (
        .word     (req_word),
        .ctx      (ctx_reg),
        .len      (len_reg),
        .mbuf     (mbuf_reg),
        .ctx_next (ctx_next),
        .len_next (len_next),
        .buf_wr   (buf_wr),
        .res      (step_res)
    );

    // Parser context.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctx_reg.st   <= hrhp_pkg::ST_METHOD;
            ctx_reg.nib  <= 4'h0;
            ctx_reg.meth <= 3'd0;
            ctx_reg.form <= hrhp_pkg::FORM_NONE;
            ctx_reg.saw  <= 1'b0;
            len_reg      <= '0;
        end else if (accept) begin
            ctx_reg <= ctx_next;
            len_reg <= len_next;
        end
    end

    // Method token bytes; only bytes below the token length are ever compared.
    always_ff @(posedge clk)
    begin
        if (accept && buf_wr) begin
            mbuf_reg[len_reg[IW-1:0]*8 +: 8] <= req_word.data_byte_in;
        end
    end

    // Result register with a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (taken) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept;
                end
            end else if (accept) begin
                if (out_valid_reg) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Result payloads.
    always_ff @(posedge clk)
    begin
        if (taken) begin
            out_reg <= skid_valid_reg ? skid_reg : step_res;
        end else if (accept) begin
            if (out_valid_reg) begin
                skid_reg <= step_res;
            end else begin
                out_reg <= step_res;
            end
        end
    end

endmodule
`default_nettype wire

// File: design/hrhp_checker.sv
// Port checker for the request head parser and its bind to the top level.
`default_nettype none
module hrhp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_stall,
    input hrhp_pkg::res_word_t res_word
);

    // A stalled result word stays on the port unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("result word changed while stalled");

    // A failure carries no byte.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.status == hrhp_pkg::STATUS_FAIL |->
        res_word.byte_kind == hrhp_pkg::KIND_NONE &&
        res_word.data_byte_out == 8'h00 && !res_word.header_start)
        else $error("failure word carries a byte");

    // The method code and the target form stay zero until the method has matched.
    a_method_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_word.method_valid |->
        res_word.method_code == 3'd0 && res_word.target_form == hrhp_pkg::FORM_NONE)
        else $error("method or form reported before method match");

    // A header start marks a header name byte.
    a_hdr_start: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.header_start |->
        res_word.byte_kind == hrhp_pkg::KIND_HNAME && res_word.method_valid)
        else $error("header start on a byte that is not a header name");

endmodule

bind http_request_head_parser hrhp_checker u_hrhp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
);
`default_nettype wire
